/* src/mlm_pkg.sv */
// Shared widths, command and status codes, and the classified request type.
`default_nettype none
package mlm_pkg;

	localparam int CMD_W  = 3;
	localparam int IDX_W  = 6;
	localparam int TID_W  = 8;
	localparam int KIND_W = 2;
	localparam int ST_W   = 3;

	localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_LOCK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TRYLOCK = 3'd3;
	localparam logic [CMD_W-1:0] CMD_UNLOCK  = 3'd4;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_INVALID  = 3'd1;
	localparam logic [ST_W-1:0] ST_NOSLOT   = 3'd2;
	localparam logic [ST_W-1:0] ST_BUSY     = 3'd3;
	localparam logic [ST_W-1:0] ST_DEADLOCK = 3'd4;
	localparam logic [ST_W-1:0] ST_NOTOWNER = 3'd5;
	localparam logic [ST_W-1:0] ST_BLOCKED  = 3'd6;
	localparam logic [ST_W-1:0] ST_NOTHREAD = 3'd7;

	localparam logic [KIND_W-1:0] KIND_RECURSIVE = 2'd2;

	localparam int Q_DEPTH = 2;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	localparam int SCAN_W  = 8;
	localparam int SCAN_AW = $clog2(SCAN_W);

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  slot;
		logic [TID_W-1:0]  thread;
		logic [KIND_W-1:0] kind;
		logic              bad_cmd;
		logic              bad_slot;
		logic              bad_thread;
	} mlm_op_t;

endpackage
`default_nettype wire

/* src/mlm_if.sv */
// Request and response channel interfaces of the mutex lock manager.
`default_nettype none
interface mlm_req_if;
	import mlm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [IDX_W-1:0]  mutex_index;
	logic [TID_W-1:0]  thread_id;
	logic [KIND_W-1:0] mutex_kind;

	modport source (output valid, output cmd, output mutex_index, output thread_id,
		output mutex_kind, input ready);
	modport sink (input valid, input cmd, input mutex_index, input thread_id,
		input mutex_kind, output ready);
endinterface

interface mlm_rsp_if;
	import mlm_pkg::*;
	logic             valid;
	logic             ready;
	logic [ST_W-1:0]  status;
	logic [IDX_W-1:0] new_mutex_index;
	logic             woken_valid;
	logic [TID_W-1:0] woken_thread;

	modport source (output valid, output status, output new_mutex_index,
		output woken_valid, output woken_thread, input ready);
	modport sink (input valid, input status, input new_mutex_index,
		input woken_valid, input woken_thread, output ready);
endinterface
`default_nettype wire

/* src/mlm_front.sv */
// Front end: accepts requests and classifies command, slot and thread checks.
`default_nettype none
module mlm_front import mlm_pkg::*; #(
	parameter int MUTEX_SLOTS  = 64,
	parameter int THREAD_SLOTS = 256
) (
	mlm_req_if.sink  req,
	input  logic     q_full,
	output logic     push,
	output mlm_op_t  op
);

	assign req.ready = !q_full;
	assign push      = req.valid && !q_full;

	always_comb begin
		op.cmd        = req.cmd;
		op.slot       = req.mutex_index;
		op.thread     = req.thread_id;
		op.kind       = req.mutex_kind;
		op.bad_cmd    = req.cmd > CMD_UNLOCK;
		op.bad_slot   = (req.mutex_index == '0) || (32'(req.mutex_index) >= MUTEX_SLOTS);
		op.bad_thread = (req.thread_id == '0) || (32'(req.thread_id) >= THREAD_SLOTS);
	end

endmodule
`default_nettype wire

/* src/mlm_queue.sv */
// Short request queue between the front end and the execution back end.
`default_nettype none
module mlm_queue import mlm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  mlm_op_t push_item,
	output logic    full,
	input  logic    pop,
	output logic    avail,
	output mlm_op_t head_item
);

	mlm_op_t          slots_q [Q_DEPTH];
	logic [Q_AW-1:0]  wr_ptr_q;
	logic [Q_AW-1:0]  rd_ptr_q;
	logic [Q_AW:0]    cnt_q;

	function automatic logic [Q_AW-1:0] ptr_next(input logic [Q_AW-1:0] p);
		ptr_next = (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = cnt_q == (Q_AW+1)'(Q_DEPTH);
	assign avail     = cnt_q != '0;
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* src/mlm_back.sv */
// Back end: mutex table and waiter link memories, command sequencer and response register.
`default_nettype none
module mlm_back import mlm_pkg::*; #(
	parameter int MUTEX_SLOTS  = 64,
	parameter int THREAD_SLOTS = 256,
	parameter int COUNT_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_avail,
	input  mlm_op_t   q_item,
	output logic      q_pop,
	mlm_rsp_if.source rsp
);

	localparam int MI_W = $clog2(MUTEX_SLOTS);
	localparam int TI_W = $clog2(THREAD_SLOTS);
	localparam int NG   = (MUTEX_SLOTS + SCAN_W - 1) / SCAN_W;
	localparam int GI_W = (NG > 1) ? $clog2(NG) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_WAKE = 3'd2;
	localparam logic [2:0] S_LINK = 3'd3;
	localparam logic [2:0] S_SCAN = 3'd4;

	typedef struct packed {
		logic [KIND_W-1:0]     kind;
		logic [TI_W-1:0]       owner;
		logic [COUNT_BITS-1:0] count;
		logic [TI_W-1:0]       head;
		logic [TI_W-1:0]       tail;
	} ent_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] new_idx;
		logic             woken_valid;
		logic [TID_W-1:0] woken_thread;
	} rsp_t;

	ent_t                  ent_mem [MUTEX_SLOTS];
	logic [TI_W-1:0]       nxt_mem [THREAD_SLOTS];

	logic [2:0]            state_q, state_d;
	mlm_op_t               item_q;
	logic [MUTEX_SLOTS-1:0] in_use_q;
	logic [GI_W-1:0]       grp_q, grp_d;
	logic [TI_W-1:0]       tail_q, tail_d;
	ent_t                  ent_rd_q;
	logic [TI_W-1:0]       nxt_rd_q;
	rsp_t                  rsp_q, rsp_d;
	logic                  rsp_valid_q;
	logic                  rsp_load;

	logic                  ent_we;
	logic [MI_W-1:0]       ent_ra;
	logic [MI_W-1:0]       ent_wa;
	ent_t                  ent_wd;
	logic                  nxt_we;
	logic [TI_W-1:0]       nxt_wa;
	logic [TI_W-1:0]       nxt_wd;
	logic [TI_W-1:0]       nxt_ra;
	logic                  in_use_set;
	logic                  in_use_clr;
	logic [MI_W-1:0]       in_use_idx;

	logic [MI_W-1:0]       si;
	logic [TI_W-1:0]       tid;
	logic [NG*SCAN_W-1:0]  free_pad;
	logic [SCAN_W-1:0]     grp_bits;
	logic [SCAN_AW-1:0]    first_bit;
	logic [GI_W+SCAN_AW-1:0] scan_slot;

	assign si  = MI_W'(item_q.slot);
	assign tid = TI_W'(item_q.thread);

	always_comb begin
		free_pad = '0;
		for (int k = 1; k < MUTEX_SLOTS; k++) begin
			free_pad[k] = !in_use_q[k];
		end
	end

	assign grp_bits = free_pad[grp_q*SCAN_W +: SCAN_W];

	always_comb begin
		first_bit = '0;
		for (int b = SCAN_W - 1; b >= 0; b--) begin
			if (grp_bits[b]) begin
				first_bit = SCAN_AW'(b);
			end
		end
	end

	assign scan_slot = {grp_q, first_bit};

	always_comb begin
		state_d    = state_q;
		q_pop      = 1'b0;
		grp_d      = grp_q;
		tail_d     = tail_q;
		ent_ra     = (state_q == S_IDLE) ? MI_W'(q_item.slot) : si;
		ent_we     = 1'b0;
		ent_wa     = si;
		ent_wd     = ent_rd_q;
		nxt_we     = 1'b0;
		nxt_wa     = tid;
		nxt_wd     = '0;
		nxt_ra     = ent_rd_q.head;
		in_use_set = 1'b0;
		in_use_clr = 1'b0;
		in_use_idx = si;
		rsp_load   = 1'b0;
		rsp_d      = '0;
		unique case (state_q)
			S_IDLE: begin
				if (q_avail && (!rsp_valid_q || rsp.ready)) begin
					q_pop = 1'b1;
					grp_d = '0;
					state_d = (q_item.cmd == CMD_CREATE) ? S_SCAN : S_EXEC;
				end
			end
			S_EXEC: begin
				rsp_load = 1'b1;
				state_d  = S_IDLE;
				rsp_d.status = ST_OK;
				if (item_q.bad_cmd || item_q.bad_slot || !in_use_q[si]) begin
					rsp_d.status = ST_INVALID;
				end else if (item_q.cmd == CMD_DESTROY) begin
					if (ent_rd_q.owner != '0) begin
						rsp_d.status = ST_BUSY;
					end else begin
						in_use_clr = 1'b1;
					end
				end else if (item_q.bad_thread) begin
					rsp_d.status = ST_NOTHREAD;
				end else if (item_q.cmd == CMD_LOCK || item_q.cmd == CMD_TRYLOCK) begin
					if (ent_rd_q.owner == tid) begin
						if (ent_rd_q.kind == KIND_RECURSIVE) begin
							if (&ent_rd_q.count) begin
								rsp_d.status = ST_BUSY;
							end else begin
								ent_we       = 1'b1;
								ent_wd.count = ent_rd_q.count + COUNT_BITS'(1);
							end
						end else begin
							rsp_d.status = ST_DEADLOCK;
						end
					end else if (ent_rd_q.owner == '0) begin
						ent_we       = 1'b1;
						ent_wd.owner = tid;
						ent_wd.count = COUNT_BITS'(1);
					end else if (item_q.cmd == CMD_TRYLOCK) begin
						rsp_d.status = ST_BUSY;
					end else begin
						ent_we      = 1'b1;
						ent_wd.tail = tid;
						if (ent_rd_q.tail == '0) begin
							ent_wd.head = tid;
						end
						nxt_we = 1'b1;
						rsp_d.status = ST_BLOCKED;
						if (ent_rd_q.tail != '0) begin
							tail_d   = ent_rd_q.tail;
							rsp_load = 1'b0;
							state_d  = S_LINK;
						end
					end
				end else begin
					if (ent_rd_q.owner != tid) begin
						rsp_d.status = ST_NOTOWNER;
					end else if (ent_rd_q.kind == KIND_RECURSIVE &&
						ent_rd_q.count > COUNT_BITS'(1)) begin
						ent_we       = 1'b1;
						ent_wd.count = ent_rd_q.count - COUNT_BITS'(1);
					end else if (ent_rd_q.head != '0) begin
						rsp_load = 1'b0;
						state_d  = S_WAKE;
					end else begin
						ent_we       = 1'b1;
						ent_wd.owner = '0;
						ent_wd.count = '0;
					end
				end
			end
			S_WAKE: begin
				ent_we       = 1'b1;
				ent_wd.head  = nxt_rd_q;
				ent_wd.tail  = (nxt_rd_q == '0) ? '0 : ent_rd_q.tail;
				ent_wd.owner = ent_rd_q.head;
				ent_wd.count = COUNT_BITS'(1);
				nxt_we       = 1'b1;
				nxt_wa       = ent_rd_q.head;
				rsp_load           = 1'b1;
				rsp_d.status       = ST_OK;
				rsp_d.woken_valid  = 1'b1;
				rsp_d.woken_thread = TID_W'(ent_rd_q.head);
				state_d = S_IDLE;
			end
			S_LINK: begin
				nxt_we       = 1'b1;
				nxt_wa       = tail_q;
				nxt_wd       = tid;
				rsp_load     = 1'b1;
				rsp_d.status = ST_BLOCKED;
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				if (|grp_bits) begin
					ent_we        = 1'b1;
					ent_wa        = MI_W'(scan_slot);
					ent_wd.kind   = item_q.kind;
					ent_wd.owner  = '0;
					ent_wd.count  = '0;
					ent_wd.head   = '0;
					ent_wd.tail   = '0;
					in_use_set    = 1'b1;
					in_use_idx    = MI_W'(scan_slot);
					rsp_load      = 1'b1;
					rsp_d.status  = ST_OK;
					rsp_d.new_idx = IDX_W'(scan_slot);
					state_d       = S_IDLE;
				end else if (grp_q == GI_W'(NG - 1)) begin
					rsp_load     = 1'b1;
					rsp_d.status = ST_NOSLOT;
					state_d      = S_IDLE;
				end else begin
					grp_d = grp_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ent_we) begin
			ent_mem[ent_wa] <= ent_wd;
		end
		ent_rd_q <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (nxt_we) begin
			nxt_mem[nxt_wa] <= nxt_wd;
		end
		nxt_rd_q <= nxt_mem[nxt_ra];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
		grp_q  <= grp_d;
		tail_q <= tail_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_use_set) begin
				in_use_q[in_use_idx] <= 1'b1;
			end
			if (in_use_clr) begin
				in_use_q[in_use_idx] <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_q.status;
	assign rsp.new_mutex_index = rsp_q.new_idx;
	assign rsp.woken_valid     = rsp_q.woken_valid;
	assign rsp.woken_thread    = rsp_q.woken_thread;

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == S_IDLE)
		else $error("Request taken from the queue outside the idle state.");

	a_slot0_free: assert property (@(posedge clk) disable iff (!arst_n)
		!in_use_q[0])
		else $error("Slot zero was marked in use.");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> state_q == S_IDLE && rsp_valid_q)
		else $error("Sequencer did not return to idle after a response.");

	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.woken_valid |-> rsp_q.status == ST_OK)
		else $error("A wake-up was reported with a failing status.");

endmodule
`default_nettype wire

/* src/mutex_lock_manager.sv */
// Top level of the mutex lock manager: front end, request queue and back end.
//
//   channel  direction  payload
//   req      in         cmd, mutex_index, thread_id, mutex_kind
//   rsp      out        status, new_mutex_index, woken_valid, woken_thread
//
// Lock, trylock, destroy and most unlocks read the mutex entry in the back end, then
// update it. An unlock that wakes a waiter, and a lock that queues behind an existing
// waiter, add a wake or link step, limited by the single waiter link port.
// Create scans the slot bitmap 8 slots per cycle.
// Reset clears the slot bitmap and all control state; no clearing pass is needed.
// The front queue holds two requests, so requests are accepted while a response waits.
`default_nettype none
module mutex_lock_manager import mlm_pkg::*; #(
	parameter int MUTEX_SLOTS  = 64,
	parameter int THREAD_SLOTS = 256,
	parameter int COUNT_BITS   = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	mlm_req_if.sink   req,
	mlm_rsp_if.source rsp
);

	logic    push;
	logic    q_full;
	logic    q_avail;
	logic    q_pop;
	mlm_op_t push_item;
	mlm_op_t head_item;

	mlm_front #(
		.MUTEX_SLOTS  (MUTEX_SLOTS),
		.THREAD_SLOTS (THREAD_SLOTS)
	) u_front (
		.req    (req),
		.q_full (q_full),
		.push   (push),
		.op     (push_item)
	);

	mlm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.avail     (q_avail),
		.head_item (head_item)
	);

	mlm_back #(
		.MUTEX_SLOTS  (MUTEX_SLOTS),
		.THREAD_SLOTS (THREAD_SLOTS),
		.COUNT_BITS   (COUNT_BITS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_item  (head_item),
		.q_pop   (q_pop),
		.rsp     (rsp)
	);

endmodule
`default_nettype wire
